[sv/ssue_pkg.sv]
// Shared types and constants of the per-column count sketch with bottom-k id samples.
// Holds the transaction structs, the controller command and status bundles and the sizing.
// No dependencies; every other file of the block but ssue_ram imports it.
package ssue_pkg;

  localparam int MAX_COLUMNS = 4;
  localparam int MAX_ROWS    = 8;
  localparam int MAX_WIDTH   = 16;
  localparam int MAX_SAMPLE  = 256;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int J_W     = $clog2(MAX_WIDTH);
  localparam int BKT_W   = COL_W + ROW_W + J_W;
  localparam int NBKT    = MAX_COLUMNS * MAX_ROWS * MAX_WIDTH;
  localparam int SLOT_W  = $clog2(MAX_SAMPLE);
  localparam int FILL_W  = $clog2(MAX_SAMPLE + 1);
  localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int SAMP_AW = BKT_W + SLOT_W;
  localparam int DIV_W   = (FILL_W > WCNT_W) ? FILL_W : WCNT_W;

  localparam int WORD_W    = 32;
  localparam int EST_W     = 42;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WORD_W-1:0] RANK_SEED = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_SIZE   = 3'd0,
    CFG_SKETCH_WIDTH  = 3'd1,
    CFG_SKETCH_HEIGHT = 3'd2,
    CFG_COLUMN_COUNT  = 3'd3,
    CFG_HASH_SEED     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              action;
    logic              record_start;
    logic              record_end;
    logic [1:0]        column;
    logic [WORD_W-1:0] value_hash;
  } in_item_t;

  typedef struct packed {
    logic [EST_W-1:0]  estimate;
    logic              estimate_valid;
    logic [WORD_W-1:0] record_total;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] total;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] max_slot;
    logic [WORD_W-1:0] max_hash;
  } bmeta_t;

  typedef enum logic [1:0] {
    H_ID   = 2'd0,
    H_RANK = 2'd1,
    H_ROW  = 2'd2,
    H_SAMP = 2'd3
  } hsel_t;

  typedef enum logic {
    D_ROW = 1'b0,
    D_EST = 1'b1
  } dsel_t;

  typedef struct packed {
    logic  clr_wr;
    logic  load_item;
    logic  rec_inc;
    logic  hash_go;
    hsel_t hsel;
    logic  id_load;
    logic  rank_load;
    logic  div_go;
    dsel_t dsel;
    logic  bkt_load;
    logic  row_clr;
    logic  row_inc;
    logic  meta_load;
    logic  tot_inc;
    logic  app;
    logic  repl;
    logic  meta_wr;
    logic  k_clr;
    logic  k_inc;
    logic  scan_cmp;
    logic  scan_commit;
    logic  q_clear;
    logic  qmax_upd;
    logic  copy_wr;
    logic  cc_from_fill;
    logic  first_clr;
    logic  i_clr;
    logic  i_inc;
    logic  kept_clr;
    logic  cand_lat;
    logic  keep_wr;
    logic  cc_from_kept;
    logic  mul;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_col;
    logic is_query;
    logic is_start;
    logic est_flag;
    logic hash_done;
    logic div_done;
    logic row_last;
    logic fill_lt_ss;
    logic fill_zero;
    logic rank_lt_max;
    logic first;
    logic k_last;
    logic cc_zero;
    logic i_last;
    logic match;
    logic out_free;
  } stat_t;

endpackage

[sv/ssue_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ssue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ssue_hash.sv]
// 32-bit xxHash of one little-endian word, one multiply per cycle.
// Depends on ssue_pkg.
module ssue_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ssue_pkg::WORD_W-1:0] val,
  input  logic [ssue_pkg::WORD_W-1:0] seed,
  output logic                       done,
  output logic [ssue_pkg::WORD_W-1:0] res
);
  import ssue_pkg::*;

  localparam logic [WORD_W-1:0] P2 = 32'h85EB_CA77;
  localparam logic [WORD_W-1:0] P3 = 32'hC2B2_AE3D;
  localparam logic [WORD_W-1:0] P4 = 32'h27D4_EB2F;
  localparam logic [WORD_W-1:0] P5_LEN = 32'h1656_67B5;
  localparam logic [1:0] LAST_STEP = 2'd2;

  logic [WORD_W-1:0] h_r, h_nxt, mul_a, mul_b, prod;
  logic [1:0]        cnt_r;
  logic              busy_r, done_r;

  always_comb begin
    mul_a = val;
    mul_b = P3;
    if (!go) begin
      case (cnt_r)
        2'd0: begin
          mul_a = {h_r[WORD_W-18:0], h_r[WORD_W-1:WORD_W-17]};
          mul_b = P4;
        end
        2'd1: begin
          mul_a = h_r ^ (h_r >> 15);
          mul_b = P2;
        end
        default: begin
          mul_a = h_r ^ (h_r >> 13);
          mul_b = P3;
        end
      endcase
    end
    prod  = mul_a * mul_b;
    h_nxt = go ? (seed + P5_LEN + prod) : prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go || busy_r) begin
      h_r <= h_nxt;
    end
  end

  assign done = done_r;
  assign res  = h_r ^ (h_r >> 16);

endmodule

[sv/ssue_div.sv]
// Radix-16 restoring divider: 32-bit dividend by a narrow divisor, four quotient bits a cycle.
// Depends on ssue_pkg.
module ssue_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [ssue_pkg::WORD_W-1:0] num,
  input  logic [ssue_pkg::DIV_W-1:0]  den,
  output logic                        done,
  output logic [ssue_pkg::WORD_W-1:0] quo,
  output logic [ssue_pkg::DIV_W-1:0]  rem
);
  import ssue_pkg::*;

  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = WORD_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [WORD_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0]  r_r, r_nxt;
  logic [DIV_W-1:0]  den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIV_W:0]    t;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    t     = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      t     = {r_nxt, q_nxt[WORD_W-1]};
      q_nxt = {q_nxt[WORD_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t        = t - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
      r_nxt = t[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      r_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

[sv/ssue_dp.sv]
// Datapath: configuration registers, record and query state, bucket and sample memories.
// Depends on ssue_pkg, ssue_ram, ssue_hash and ssue_div; driven by ssue_ctrl commands.
module ssue_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ssue_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssue_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ssue_pkg::in_item_t              in_item,
  output ssue_pkg::out_item_t             out_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  ssue_pkg::cmd_t                  cmd,
  output ssue_pkg::stat_t                 stat
);
  import ssue_pkg::*;

  logic [10:0]       ss_cfg_r;
  logic [4:0]        sw_cfg_r;
  logic [3:0]        sh_cfg_r;
  logic [2:0]        cc_cfg_r;
  logic [WORD_W-1:0] seed_r;

  logic [FILL_W-1:0] ss;
  logic [WCNT_W-1:0] w;
  logic [ROW_W-1:0]  row_last_idx;
  logic [2:0]        ncols;
  logic              bad, est_flag;

  in_item_t          item_r;
  logic [WORD_W-1:0] rec_cnt_r, id_r, rank_r, qmax_r, mh_r, c_r;
  logic [ROW_W-1:0]  row_r;
  logic [BKT_W-1:0]  bkt_r, clr_r;
  logic [WORD_W-1:0] tot_r, mhash_r;
  logic [FILL_W-1:0] fill_r, cc_r, kept_r;
  logic [SLOT_W-1:0] mslot_r, k_r, ms_r, i_r;
  logic              first_r;
  logic [EST_W-1:0]  est_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic [WORD_W-1:0] h_val, h_seed, hres;
  logic              h_done;
  logic [WORD_W-1:0] d_num, dquo;
  logic [DIV_W-1:0]  d_den, drem;
  logic              d_done;

  bmeta_t            bm_wdata, bm_rdata;
  logic              bm_we;
  logic [BKT_W-1:0]  bm_waddr;
  logic              sm_we;
  logic [SAMP_AW-1:0] sm_waddr;
  logic [WORD_W-1:0] sm_rdata;
  logic              cm_we;
  logic [SLOT_W-1:0] cm_waddr;
  logic [WORD_W-1:0] cm_wdata, cm_rdata;

  always_comb begin
    if (ss_cfg_r == '0) begin
      ss = FILL_W'(1);
    end else if (ss_cfg_r > 11'(MAX_SAMPLE)) begin
      ss = FILL_W'(MAX_SAMPLE);
    end else begin
      ss = FILL_W'(ss_cfg_r);
    end
    if (sw_cfg_r == '0) begin
      w = WCNT_W'(1);
    end else if (sw_cfg_r > 5'(MAX_WIDTH)) begin
      w = WCNT_W'(MAX_WIDTH);
    end else begin
      w = WCNT_W'(sw_cfg_r);
    end
    if (sh_cfg_r == '0) begin
      row_last_idx = '0;
    end else if (sh_cfg_r > 4'(MAX_ROWS)) begin
      row_last_idx = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last_idx = ROW_W'(sh_cfg_r - 4'd1);
    end
    ncols    = (cc_cfg_r > 3'(MAX_COLUMNS)) ? 3'(MAX_COLUMNS) : cc_cfg_r;
    bad      = {1'b0, item_r.column} >= ncols;
    est_flag = !bad && item_r.action && item_r.record_end;
  end

  always_comb begin
    unique case (cmd.hsel)
      H_ID: begin
        h_val  = rec_cnt_r + 32'd1;
        h_seed = seed_r;
      end
      H_RANK: begin
        h_val  = id_r;
        h_seed = RANK_SEED;
      end
      H_ROW: begin
        h_val  = item_r.value_hash;
        h_seed = WORD_W'(row_r);
      end
      default: begin
        h_val  = sm_rdata;
        h_seed = RANK_SEED;
      end
    endcase
    if (cmd.dsel == D_EST) begin
      d_num = qmax_r;
      d_den = DIV_W'(ss);
    end else begin
      d_num = hres;
      d_den = DIV_W'(w);
    end
  end

  ssue_hash u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.hash_go),
    .val  (h_val),
    .seed (h_seed),
    .done (h_done),
    .res  (hres)
  );

  ssue_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (d_num),
    .den  (d_den),
    .done (d_done),
    .quo  (dquo),
    .rem  (drem)
  );

  assign bm_we    = cmd.clr_wr || cmd.meta_wr;
  assign bm_waddr = cmd.clr_wr ? clr_r : bkt_r;
  assign bm_wdata = cmd.clr_wr ? '0 : {tot_r, fill_r, mslot_r, mhash_r};

  ssue_ram #(.WIDTH($bits(bmeta_t)), .DEPTH(NBKT)) u_bucket_ram (
    .clk  (clk),
    .we   (bm_we),
    .waddr(bm_waddr),
    .wdata(bm_wdata),
    .raddr(bkt_r),
    .rdata(bm_rdata)
  );

  assign sm_we    = cmd.app || cmd.repl;
  assign sm_waddr = {bkt_r, cmd.app ? fill_r[SLOT_W-1:0] : mslot_r};

  ssue_ram #(.WIDTH(WORD_W), .DEPTH(NBKT * MAX_SAMPLE)) u_sample_ram (
    .clk  (clk),
    .we   (sm_we),
    .waddr(sm_waddr),
    .wdata(id_r),
    .raddr({bkt_r, k_r}),
    .rdata(sm_rdata)
  );

  assign cm_we    = cmd.copy_wr || cmd.keep_wr;
  assign cm_waddr = cmd.copy_wr ? k_r : kept_r[SLOT_W-1:0];
  assign cm_wdata = cmd.copy_wr ? sm_rdata : c_r;

  ssue_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SAMPLE)) u_cand_ram (
    .clk  (clk),
    .we   (cm_we),
    .waddr(cm_waddr),
    .wdata(cm_wdata),
    .raddr(i_r),
    .rdata(cm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_cfg_r    <= 11'd256;
      sw_cfg_r    <= 5'd6;
      sh_cfg_r    <= 4'd6;
      cc_cfg_r    <= 3'd1;
      seed_r      <= '0;
      rec_cnt_r   <= '0;
      id_r        <= '0;
      qmax_r      <= '0;
      cc_r        <= '0;
      first_r     <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_SIZE:   ss_cfg_r <= cfg_data[10:0];
          CFG_SKETCH_WIDTH:  sw_cfg_r <= cfg_data[4:0];
          CFG_SKETCH_HEIGHT: sh_cfg_r <= cfg_data[3:0];
          CFG_COLUMN_COUNT:  cc_cfg_r <= cfg_data[2:0];
          CFG_HASH_SEED:     seed_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_r <= clr_r + BKT_W'(1);
      end
      if (cmd.rec_inc) begin
        rec_cnt_r <= rec_cnt_r + 32'd1;
      end
      if (cmd.id_load) begin
        id_r <= hres;
      end
      if (cmd.q_clear) begin
        qmax_r <= '0;
      end else if (cmd.qmax_upd && (tot_r > qmax_r)) begin
        qmax_r <= tot_r;
      end
      if (cmd.q_clear) begin
        cc_r <= '0;
      end else if (cmd.cc_from_fill) begin
        cc_r <= fill_r;
      end else if (cmd.cc_from_kept) begin
        cc_r <= kept_r;
      end
      if (cmd.q_clear) begin
        first_r <= 1'b1;
      end else if (cmd.first_clr) begin
        first_r <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.rank_load) begin
      rank_r <= hres;
    end
    if (cmd.row_clr) begin
      row_r <= '0;
    end else if (cmd.row_inc) begin
      row_r <= row_r + ROW_W'(1);
    end
    if (cmd.bkt_load) begin
      bkt_r <= {item_r.column[COL_W-1:0], row_r, drem[J_W-1:0]};
    end
    if (cmd.meta_load) begin
      tot_r   <= bm_rdata.total;
      fill_r  <= bm_rdata.fill;
      mslot_r <= bm_rdata.max_slot;
      mhash_r <= bm_rdata.max_hash;
    end else begin
      if (cmd.tot_inc) begin
        tot_r <= tot_r + 32'd1;
      end
      if (cmd.app) begin
        fill_r <= fill_r + FILL_W'(1);
        if (fill_r == '0) begin
          mslot_r <= '0;
          mhash_r <= rank_r;
        end else if (rank_r > mhash_r) begin
          mslot_r <= fill_r[SLOT_W-1:0];
          mhash_r <= rank_r;
        end
      end
      if (cmd.scan_commit) begin
        mslot_r <= ms_r;
        mhash_r <= mh_r;
      end
    end
    if (cmd.repl) begin
      mh_r <= '0;
      ms_r <= '0;
    end else if (cmd.scan_cmp && (hres >= mh_r)) begin
      mh_r <= hres;
      ms_r <= k_r;
    end
    if (cmd.k_clr || cmd.repl) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + SLOT_W'(1);
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + SLOT_W'(1);
    end
    if (cmd.kept_clr) begin
      kept_r <= '0;
    end else if (cmd.keep_wr) begin
      kept_r <= kept_r + FILL_W'(1);
    end
    if (cmd.cand_lat) begin
      c_r <= cm_rdata;
    end
    if (cmd.mul) begin
      est_r <= EST_W'(dquo) * EST_W'(cc_r);
    end
    if (cmd.out_load) begin
      out_r.estimate       <= est_flag ? est_r : '0;
      out_r.estimate_valid <= est_flag;
      out_r.record_total   <= rec_cnt_r;
      out_r.status         <= bad;
    end
  end

  always_comb begin
    stat.clr_last    = (clr_r == BKT_W'(NBKT - 1));
    stat.bad_col     = bad;
    stat.is_query    = item_r.action;
    stat.is_start    = item_r.record_start;
    stat.est_flag    = est_flag;
    stat.hash_done   = h_done;
    stat.div_done    = d_done;
    stat.row_last    = (row_r == row_last_idx);
    stat.fill_lt_ss  = (fill_r < ss);
    stat.fill_zero   = (fill_r == '0);
    stat.rank_lt_max = (rank_r < mhash_r);
    stat.first       = first_r;
    stat.k_last      = ((FILL_W'(k_r) + FILL_W'(1)) == fill_r);
    stat.cc_zero     = (cc_r == '0);
    stat.i_last      = ((FILL_W'(i_r) + FILL_W'(1)) == cc_r);
    stat.match       = (sm_rdata == c_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

[sv/ssue_ctrl.sv]
// Controller: one-hot state machine sequencing clear, add, replace, rescan and query steps.
// Depends on ssue_pkg; issues commands to ssue_dp and reads its status.
module ssue_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output ssue_pkg::cmd_t  cmd,
  input  ssue_pkg::stat_t stat
);
  import ssue_pkg::*;

  localparam int ST_W = 28;

  typedef enum logic [ST_W-1:0] {
    S_CLEAR = ST_W'(1) << 0,
    S_IDLE  = ST_W'(1) << 1,
    S_CHECK = ST_W'(1) << 2,
    S_IDH   = ST_W'(1) << 3,
    S_RKGO  = ST_W'(1) << 4,
    S_RANKH = ST_W'(1) << 5,
    S_ROWGO = ST_W'(1) << 6,
    S_ROWH  = ST_W'(1) << 7,
    S_DIV   = ST_W'(1) << 8,
    S_BRD   = ST_W'(1) << 9,
    S_BDAT  = ST_W'(1) << 10,
    S_BOP   = ST_W'(1) << 11,
    S_SRD   = ST_W'(1) << 12,
    S_SDAT  = ST_W'(1) << 13,
    S_SH    = ST_W'(1) << 14,
    S_SFIN  = ST_W'(1) << 15,
    S_BWR   = ST_W'(1) << 16,
    S_CRD   = ST_W'(1) << 17,
    S_CWR   = ST_W'(1) << 18,
    S_QCRD  = ST_W'(1) << 19,
    S_QCDAT = ST_W'(1) << 20,
    S_QSRD  = ST_W'(1) << 21,
    S_QSCMP = ST_W'(1) << 22,
    S_QKEEP = ST_W'(1) << 23,
    S_QNEXT = ST_W'(1) << 24,
    S_NEXT  = ST_W'(1) << 25,
    S_EDIV  = ST_W'(1) << 26,
    S_FIN   = ST_W'(1) << 27
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_col) begin
          state_nxt = S_FIN;
        end else if (stat.is_query) begin
          cmd.q_clear = stat.is_start;
          cmd.row_clr = 1'b1;
          state_nxt   = S_ROWGO;
        end else if (stat.is_start) begin
          cmd.rec_inc = 1'b1;
          cmd.hash_go = 1'b1;
          cmd.hsel    = H_ID;
          state_nxt   = S_IDH;
        end else begin
          state_nxt = S_RKGO;
        end
      end
      S_IDH: begin
        if (stat.hash_done) begin
          cmd.id_load = 1'b1;
          state_nxt   = S_RKGO;
        end
      end
      S_RKGO: begin
        cmd.hash_go = 1'b1;
        cmd.hsel    = H_RANK;
        state_nxt   = S_RANKH;
      end
      S_RANKH: begin
        if (stat.hash_done) begin
          cmd.rank_load = 1'b1;
          cmd.row_clr   = 1'b1;
          state_nxt     = S_ROWGO;
        end
      end
      S_ROWGO: begin
        cmd.hash_go = 1'b1;
        cmd.hsel    = H_ROW;
        state_nxt   = S_ROWH;
      end
      S_ROWH: begin
        if (stat.hash_done) begin
          cmd.div_go = 1'b1;
          cmd.dsel   = D_ROW;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.bkt_load = 1'b1;
          state_nxt    = S_BRD;
        end
      end
      S_BRD: begin
        state_nxt = S_BDAT;
      end
      S_BDAT: begin
        cmd.meta_load = 1'b1;
        state_nxt     = S_BOP;
      end
      S_BOP: begin
        if (!stat.is_query) begin
          cmd.tot_inc = 1'b1;
          if (stat.fill_lt_ss) begin
            cmd.app   = 1'b1;
            state_nxt = S_BWR;
          end else if (stat.rank_lt_max) begin
            cmd.repl  = 1'b1;
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_BWR;
          end
        end else begin
          cmd.qmax_upd = 1'b1;
          if (stat.first) begin
            if (stat.fill_zero) begin
              cmd.cc_from_fill = 1'b1;
              cmd.first_clr    = 1'b1;
              state_nxt        = S_NEXT;
            end else begin
              cmd.k_clr = 1'b1;
              state_nxt = S_CRD;
            end
          end else if (stat.cc_zero) begin
            state_nxt = S_NEXT;
          end else begin
            cmd.i_clr    = 1'b1;
            cmd.kept_clr = 1'b1;
            state_nxt    = S_QCRD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SDAT;
      end
      S_SDAT: begin
        cmd.hash_go = 1'b1;
        cmd.hsel    = H_SAMP;
        state_nxt   = S_SH;
      end
      S_SH: begin
        if (stat.hash_done) begin
          cmd.scan_cmp = 1'b1;
          if (stat.k_last) begin
            state_nxt = S_SFIN;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_SFIN: begin
        cmd.scan_commit = 1'b1;
        state_nxt       = S_BWR;
      end
      S_BWR: begin
        cmd.meta_wr = 1'b1;
        state_nxt   = S_NEXT;
      end
      S_CRD: begin
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.copy_wr = 1'b1;
        if (stat.k_last) begin
          cmd.cc_from_fill = 1'b1;
          cmd.first_clr    = 1'b1;
          state_nxt        = S_NEXT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_QCRD: begin
        state_nxt = S_QCDAT;
      end
      S_QCDAT: begin
        cmd.cand_lat = 1'b1;
        cmd.k_clr    = 1'b1;
        state_nxt    = stat.fill_zero ? S_QNEXT : S_QSRD;
      end
      S_QSRD: begin
        state_nxt = S_QSCMP;
      end
      S_QSCMP: begin
        if (stat.match) begin
          state_nxt = S_QKEEP;
        end else if (stat.k_last) begin
          state_nxt = S_QNEXT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_QSRD;
        end
      end
      S_QKEEP: begin
        cmd.keep_wr = 1'b1;
        state_nxt   = S_QNEXT;
      end
      S_QNEXT: begin
        if (stat.i_last) begin
          cmd.cc_from_kept = 1'b1;
          state_nxt        = S_NEXT;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_QCRD;
        end
      end
      S_NEXT: begin
        if (!stat.row_last) begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_ROWGO;
        end else if (stat.est_flag) begin
          cmd.div_go = 1'b1;
          cmd.dsel   = D_EST;
          state_nxt  = S_EDIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EDIV: begin
        cmd.dsel = D_EST;
        if (stat.div_done) begin
          cmd.mul   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/sketch_sample_update_and_estimate.sv]
// Top level of the per-column count sketch with bottom-k id samples and query estimate.
// Depends on ssue_pkg, ssue_ctrl and ssue_dp.
//
//   channel  ports                            transaction
//   input    in_valid / in_ready / in_data    one column item (add or query)
//   result   out_valid / out_ready / out_data one result per item
//   config   cfg_we / cfg_index / cfg_data    register write, no wait
//
// One item at a time. An add runs per row a hash, a remainder division and a bucket
// read-modify-write; the id hash is skipped without a record start. A full sample whose
// maximum is displaced adds a rescan of its filled entries in turn, each read and hashed
// again. A query runs the hash, division and bucket read per row, then copies the ids
// of a record's first bucket or intersects the candidates with later ones; a query record
// end adds the estimate division. After reset 512 bucket entries are cleared with in_ready
// low. A finished result waits in the output register; the next item is taken meanwhile.
module sketch_sample_update_and_estimate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssue_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssue_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ssue_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssue_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssue_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ssue_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  ssue_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_data),
    .out_item (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
